@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

	localparam int PAGE_COUNT = 1024;
	localparam int TOP_ORDER  = 10;

	// Port field widths.
	localparam int CMD_W    = 1;
	localparam int ORDER_W  = 4;
	localparam int PIDX_W   = 10;
	localparam int STATUS_W = 2;

	// Internal widths.
	localparam int IDX_W  = TOP_ORDER;
	localparam int KW     = $clog2(TOP_ORDER + 2);
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	localparam int WC_W   = (IDX_W > BIT_W) ? IDX_W - BIT_W : 1;
	localparam int PAGE_W = $clog2(PAGE_COUNT);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NO_BLOCK  = 2'd1;
	localparam status_t ST_TOO_LARGE = 2'd2;
	localparam status_t ST_NOT_ALLOC = 2'd3;

	// Number of map words that hold the nodes of order k.
	function automatic int fm_wcnt(input int k);
		int sh;
		sh = TOP_ORDER - k - BIT_W;
		return (sh > 0) ? (1 << sh) : 1;
	endfunction

	// First map word of order k; orders are stored one after another.
	function automatic int fm_base(input int k);
		int s;
		s = 0;
		for (int j = 0; j <= TOP_ORDER; j++) begin
			if (j < k) begin
				s = s + fm_wcnt(j);
			end
		end
		return s;
	endfunction

	// Bits of a map word that hold real nodes of order k.
	function automatic logic [WORD_W-1:0] fm_mask(input int k);
		int cnt;
		cnt = TOP_ORDER - k;
		if (cnt >= BIT_W) begin
			return '1;
		end
		return (WORD_W'(1) << (1 << cnt)) - WORD_W'(1);
	endfunction

	localparam int FM_WORDS   = fm_base(TOP_ORDER + 1);
	localparam int FM_AW      = (FM_WORDS > 1) ? $clog2(FM_WORDS) : 1;
	localparam int FM_TOP     = fm_base(TOP_ORDER);
	localparam int FLAG_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
	localparam int FLAG_AW    = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;
	localparam int CLR_WORDS  = (FM_WORDS > FLAG_WORDS) ? FM_WORDS : FLAG_WORDS;
	localparam int CLR_W      = (CLR_WORDS > 1) ? $clog2(CLR_WORDS) : 1;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [KW-1:0]    k;
	} node_req_t;

	typedef struct packed {
		logic [FM_AW-1:0]  addr;
		logic [WORD_W-1:0] bsel;
		logic [BIT_W-1:0]  low;
		logic              any;
	} node_rsp_t;

endpackage

@@ hw/rtl/bpa_word_ram.sv @@
module bpa_word_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

@@ hw/rtl/bpa_node_unit.sv @@
module bpa_node_unit (
	input  bpa_pkg::node_req_t        req,
	input  logic [bpa_pkg::WORD_W-1:0] word,
	output bpa_pkg::node_rsp_t        rsp
);
	import bpa_pkg::*;

	logic [IDX_W-1:0]  pos;
	logic [WORD_W-1:0] masked;

	// Maps a (page, order) node to its map word and bit, and finds the lowest
	// free node among the valid bits of the word just read.
	always_comb begin
		pos      = req.idx >> req.k;
		rsp.addr = FM_AW'(fm_base(int'(req.k))) + FM_AW'(pos >> BIT_W);
		rsp.bsel = WORD_W'(1) << pos[BIT_W-1:0];
		masked   = word & fm_mask(int'(req.k));
		rsp.any  = |masked;
		rsp.low  = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (masked[i]) begin
				rsp.low = BIT_W'(i);
			end
		end
	end

endmodule

@@ hw/rtl/buddy_page_allocator_unit.sv @@
// Channel   Handshake           Payload
// command   start / busy        cmd, req_order, page_index
// result    done (strobe)       status, block_index, block_order
//
// A command beat is taken when start is high and busy is low; one result
// beat follows for every command, shown for one cycle with done high.
// Allocate reads the free map one 32-bit word at a time, from the asked order
// upward, until it finds a free block; it then splits that block down to the
// asked order and sets the allocation flag of the block that it returns.
// Free clears the page flag, merges with each free buddy and frees the result.
// After reset the block sweeps its maps with busy high.
// The result side cannot stall; the output registers are simply overwritten
// by the next result.
module buddy_page_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bpa_pkg::CMD_W-1:0]     cmd,
	input  logic [bpa_pkg::ORDER_W-1:0]   req_order,
	input  logic [bpa_pkg::PIDX_W-1:0]    page_index,
	output logic                          done,
	output logic [bpa_pkg::STATUS_W-1:0]  status,
	output logic [bpa_pkg::PIDX_W-1:0]    block_index,
	output logic [bpa_pkg::ORDER_W-1:0]   block_order
);
	import bpa_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_ERR,
		S_A_RD, S_A_CHK, S_A_SP_RD, S_A_SP_WR, S_A_FL_RD, S_A_FL_WR,
		S_F_RD, S_F_CHK, S_F_BD_RD, S_F_BD_CHK, S_F_SET_RD, S_F_SET_WR
	} state_t;

	state_t            st_q;
	logic [CLR_W-1:0]  clr_q;
	logic [KW-1:0]     k_q;
	logic [KW-1:0]     r_q;
	logic [KW-1:0]     j_q;
	logic [WC_W-1:0]   w_q;
	logic [IDX_W-1:0]  idx_q;
	status_t           err_q;
	logic              done_q;
	status_t           status_q;
	logic [PIDX_W-1:0] bidx_q;
	logic [ORDER_W-1:0] bord_q;

	node_req_t         nreq;
	node_rsp_t         nrsp;
	logic [KW-1:0]     jm1;

	logic              fm_we;
	logic [FM_AW-1:0]  fm_wa;
	logic [WORD_W-1:0] fm_wd;
	logic [WORD_W-1:0] fm_rd;

	logic              fl_we;
	logic [FLAG_AW-1:0] fl_addr;
	logic [WORD_W-1:0] fl_wd;
	logic [WORD_W-1:0] fl_rd;
	logic [WORD_W-1:0] fl_bit;

	logic              or_we;
	logic [KW-1:0]     or_rd;

	logic [IDX_W-1:0]  found_idx;
	logic              accept;

	assign accept  = start && (st_q == S_IDLE);
	assign jm1     = j_q - KW'(1);
	assign fl_addr = FLAG_AW'(idx_q >> BIT_W);
	assign fl_bit  = WORD_W'(1) << idx_q[BIT_W-1:0];
	assign found_idx = {w_q, nrsp.low} << k_q;

	// The node the shared locate unit works on in each state.
	always_comb begin
		nreq.idx = idx_q;
		nreq.k   = k_q;
		case (st_q)
			S_A_RD, S_A_CHK: begin
				nreq.idx = {w_q, {BIT_W{1'b0}}} << k_q;
			end
			S_A_SP_RD, S_A_SP_WR: begin
				nreq.idx = idx_q + (IDX_W'(1) << jm1);
				nreq.k   = jm1;
			end
			S_F_BD_RD, S_F_BD_CHK: begin
				nreq.idx = idx_q ^ (IDX_W'(1) << k_q);
			end
			default: begin
				nreq.idx = idx_q;
			end
		endcase
	end

	bpa_node_unit u_node (
		.req  (nreq),
		.word (fm_rd),
		.rsp  (nrsp)
	);

	// Free-map write port: the sweep after reset, then read-modify-write of
	// the word the locate unit points at.
	always_comb begin
		fm_we = 1'b0;
		fm_wa = nrsp.addr;
		fm_wd = fm_rd;
		case (st_q)
			S_CLR: begin
				fm_we = int'(clr_q) < FM_WORDS;
				fm_wa = FM_AW'(clr_q);
				fm_wd = (int'(clr_q) == FM_TOP) ? WORD_W'(1) : '0;
			end
			S_A_CHK: begin
				fm_we = nrsp.any;
				fm_wd = fm_rd & ~(WORD_W'(1) << nrsp.low);
			end
			S_A_SP_WR, S_F_SET_WR: begin
				fm_we = 1'b1;
				fm_wd = fm_rd | nrsp.bsel;
			end
			S_F_BD_CHK: begin
				fm_we = |(fm_rd & nrsp.bsel);
				fm_wd = fm_rd & ~nrsp.bsel;
			end
			default: begin
				fm_we = 1'b0;
			end
		endcase
	end

	bpa_word_ram #(.DEPTH(FM_WORDS), .WIDTH(WORD_W)) u_free_map (
		.clk (clk),
		.we  (fm_we),
		.wa  (fm_wa),
		.wd  (fm_wd),
		.ra  (nrsp.addr),
		.rd  (fm_rd)
	);

	// Allocation flags, one bit per page, packed into words.
	always_comb begin
		fl_we = 1'b0;
		fl_wd = fl_rd;
		case (st_q)
			S_CLR: begin
				fl_we = int'(clr_q) < FLAG_WORDS;
				fl_wd = '0;
			end
			S_A_FL_WR: begin
				fl_we = 1'b1;
				fl_wd = fl_rd | fl_bit;
			end
			S_F_CHK: begin
				fl_we = |(fl_rd & fl_bit);
				fl_wd = fl_rd & ~fl_bit;
			end
			default: begin
				fl_we = 1'b0;
			end
		endcase
	end

	bpa_word_ram #(.DEPTH(FLAG_WORDS), .WIDTH(WORD_W)) u_flag_map (
		.clk (clk),
		.we  (fl_we),
		.wa  ((st_q == S_CLR) ? FLAG_AW'(clr_q) : fl_addr),
		.wd  (fl_wd),
		.ra  (fl_addr),
		.rd  (fl_rd)
	);

	// Order of each allocated block; only read behind a set flag.
	assign or_we = (st_q == S_A_FL_WR);

	bpa_word_ram #(.DEPTH(PAGE_COUNT), .WIDTH(KW)) u_order_mem (
		.clk (clk),
		.we  (or_we),
		.wa  (PAGE_W'(idx_q)),
		.wd  (r_q),
		.ra  (PAGE_W'(idx_q)),
		.rd  (or_rd)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLR;
			clr_q    <= '0;
			k_q      <= '0;
			r_q      <= '0;
			j_q      <= '0;
			w_q      <= '0;
			idx_q    <= '0;
			err_q    <= ST_OK;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			bidx_q   <= '0;
			bord_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (int'(clr_q) == CLR_WORDS - 1) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_ALLOC) begin
							if (int'(req_order) > TOP_ORDER) begin
								err_q <= ST_TOO_LARGE;
								st_q  <= S_ERR;
							end else begin
								k_q  <= KW'(req_order);
								r_q  <= KW'(req_order);
								w_q  <= '0;
								st_q <= S_A_RD;
							end
						end else begin
							idx_q <= IDX_W'(page_index);
							if (int'(page_index) >= PAGE_COUNT) begin
								err_q <= ST_NOT_ALLOC;
								st_q  <= S_ERR;
							end else begin
								st_q <= S_F_RD;
							end
						end
					end
				end
				S_ERR: begin
					done_q   <= 1'b1;
					status_q <= err_q;
					bidx_q   <= '0;
					bord_q   <= '0;
					st_q     <= S_IDLE;
				end
				S_A_RD: begin
					st_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (nrsp.any) begin
						idx_q <= found_idx;
						j_q   <= k_q;
						st_q  <= (k_q > r_q) ? S_A_SP_RD : S_A_FL_RD;
					end else if (int'(w_q) == fm_wcnt(int'(k_q)) - 1) begin
						w_q <= '0;
						if (int'(k_q) == TOP_ORDER) begin
							err_q <= ST_NO_BLOCK;
							st_q  <= S_ERR;
						end else begin
							k_q  <= k_q + KW'(1);
							st_q <= S_A_RD;
						end
					end else begin
						w_q  <= w_q + WC_W'(1);
						st_q <= S_A_RD;
					end
				end
				S_A_SP_RD: begin
					st_q <= S_A_SP_WR;
				end
				S_A_SP_WR: begin
					j_q  <= jm1;
					st_q <= (jm1 > r_q) ? S_A_SP_RD : S_A_FL_RD;
				end
				S_A_FL_RD: begin
					if (int'(idx_q) >= PAGE_COUNT) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						bidx_q   <= PIDX_W'(idx_q);
						bord_q   <= ORDER_W'(r_q);
						st_q     <= S_IDLE;
					end else begin
						st_q <= S_A_FL_WR;
					end
				end
				S_A_FL_WR: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					bidx_q   <= PIDX_W'(idx_q);
					bord_q   <= ORDER_W'(r_q);
					st_q     <= S_IDLE;
				end
				S_F_RD: begin
					st_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (!(|(fl_rd & fl_bit))) begin
						err_q <= ST_NOT_ALLOC;
						st_q  <= S_ERR;
					end else if (int'(or_rd) >= TOP_ORDER) begin
						k_q  <= KW'(TOP_ORDER);
						st_q <= S_F_SET_RD;
					end else begin
						k_q  <= or_rd;
						st_q <= S_F_BD_RD;
					end
				end
				S_F_BD_RD: begin
					st_q <= S_F_BD_CHK;
				end
				S_F_BD_CHK: begin
					if (|(fm_rd & nrsp.bsel)) begin
						idx_q <= idx_q & ~(IDX_W'(1) << k_q);
						k_q   <= k_q + KW'(1);
						st_q  <= (int'(k_q) + 1 < TOP_ORDER) ? S_F_BD_RD : S_F_SET_RD;
					end else begin
						st_q <= S_F_SET_RD;
					end
				end
				S_F_SET_RD: begin
					st_q <= S_F_SET_WR;
				end
				S_F_SET_WR: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					bidx_q   <= PIDX_W'(idx_q);
					bord_q   <= ORDER_W'(k_q);
					st_q     <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (st_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign block_index = bidx_q;
	assign block_order = bord_q;

endmodule

@@ hw/rtl/bpa_checker.sv @@
`include "assert_macros.svh"

module bpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [bpa_pkg::STATUS_W-1:0]  status,
	input logic [bpa_pkg::PIDX_W-1:0]    block_index,
	input logic [bpa_pkg::ORDER_W-1:0]   block_order
);
	import bpa_pkg::*;

	// Every accepted command raises busy.
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	// A result ends the work of a command that was running.
	`ASSERT_SAME(a_done_after_busy, done, $past(busy) && !busy, "result without command")
	// Failed commands report an empty block.
	`ASSERT_SAME(a_err_zero, done && (status != ST_OK),
		(block_index == '0) && (block_order == '0), "error result carries a block")
	// Reported orders stay within the pool.
	`ASSERT_SAME(a_order_range, done, int'(block_order) <= TOP_ORDER, "block order too large")

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.block_index (block_index),
	.block_order (block_order)
);
